// ===== rtl/knnmd_pkg.sv =====
// Shared constants, command codes and controller/datapath types for the k-NN mean distance block.
package knnmd_pkg;

    // sizing defaults and fixed field widths
    localparam int MAX_POINTS_DEF    = 256;
    localparam int MAX_NEIGHBORS_DEF = 8;
    localparam int COORD_BITS        = 12;
    localparam int DIST_BITS         = 2 * COORD_BITS + 1;
    localparam int ROOT_BITS         = (DIST_BITS + 1) / 2;
    localparam int NC_BITS           = 4;
    localparam int FB_BITS           = 25;
    localparam int IDX_BITS          = 8;
    localparam int CMD_BITS          = 2;
    localparam int STS_BITS          = 2;
    localparam int CFG_IDX_BITS      = 1;

    localparam logic [NC_BITS-1:0] NC_RESET = 4'd5;
    localparam logic [FB_BITS-1:0] FB_RESET = 25'd11520000;

    // command codes
    localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd2;

    // result status codes
    localparam logic [STS_BITS-1:0] STS_OK    = 2'd0;
    localparam logic [STS_BITS-1:0] STS_FULL  = 2'd1;
    localparam logic [STS_BITS-1:0] STS_NOIDX = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_NEIGHBOR_COUNT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FALLBACK_SQ    = 1'd1;

    // commands from controller to datapath
    typedef struct packed {
        logic                load;
        logic                clear;
        logic                fetch;
        logic                scan_init;
        logic                scan_run;
        logic                div_start;
        logic                sq_start;
        logic                res_load;
        logic                res_root;
        logic [STS_BITS-1:0] res_status;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic idx_ok;
        logic scan_last;
        logic pipe_empty;
        logic div_done;
        logic sq_done;
    } t_dp_stat;

endpackage

// ===== rtl/knn_mean_distance.sv =====
// Top level of the k-nearest-neighbour mean distance block.
// Each transfer carries one command: load a point, clear the table or query a stored point,
// and each gives exactly one result transfer. A query sweeps the point store one entry a
// cycle, then a restoring divider produces one quotient bit a cycle and the square root
// one root bit a cycle. A finished result waits in the output register while the next
// command is taken.
module knn_mean_distance
    import knnmd_pkg::*;
#(
    parameter int MAX_POINTS    = MAX_POINTS_DEF,
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [FB_BITS-1:0]      i_cfg_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [39:0]             s_tdata,  // cmd, coord_x, coord_y, point_index, zero pad
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [15:0]             m_tdata   // mean_distance, status, zero pad
);

    logic [NC_BITS-1:0]   r_neighbor_count;
    logic [FB_BITS-1:0]   r_fallback_sq;
    t_dp_cmd              dp_cmd;
    t_dp_stat             dp_stat;
    logic [ROOT_BITS-1:0] mean_distance;
    logic [STS_BITS-1:0]  status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbor_count <= NC_RESET;
            r_fallback_sq    <= FB_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NEIGHBOR_COUNT: r_neighbor_count <= i_cfg_data[NC_BITS-1:0];
                REG_FALLBACK_SQ:    r_fallback_sq    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    knnmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_cmd_code (s_tdata[1:0]),
        .i_m_tready (m_tready),
        .i_stat     (dp_stat),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .o_cmd      (dp_cmd)
    );

    knnmd_dp #(
        .MAX_POINTS    (MAX_POINTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_coord_x        (s_tdata[13:2]),
        .i_coord_y        (s_tdata[25:14]),
        .i_point_index    (s_tdata[33:26]),
        .i_neighbor_count (r_neighbor_count),
        .i_fallback_sq    (r_fallback_sq),
        .o_mean_distance  (mean_distance),
        .o_status         (status)
    );

    assign m_tdata = {1'b0, status, mean_distance};

    // checks
    a_sts_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (status == STS_OK || status == STS_FULL || status == STS_NOIDX))
        else $error("unknown status code");

    a_dist_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && mean_distance != '0) |-> (status == STS_OK))
        else $error("distance returned with error status");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.scan_run |-> !s_tready)
        else $error("input ready during scan");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

// ===== rtl/knnmd_dp.sv =====
// Datapath: point store, distance pipeline, k-smallest sorter, divider and square root.
module knnmd_dp
    import knnmd_pkg::*;
#(
    parameter int MAX_POINTS    = MAX_POINTS_DEF,
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    input  logic [IDX_BITS-1:0]   i_point_index,
    input  logic [NC_BITS-1:0]    i_neighbor_count,
    input  logic [FB_BITS-1:0]    i_fallback_sq,
    output logic [ROOT_BITS-1:0]  o_mean_distance,
    output logic [STS_BITS-1:0]   o_status
);

    localparam int AW    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int LW    = $clog2(MAX_POINTS + 1);
    localparam int XW    = (AW > IDX_BITS) ? AW : IDX_BITS;
    localparam int CW    = (LW > IDX_BITS) ? LW : IDX_BITS;
    localparam int KW    = $clog2(MAX_NEIGHBORS + 1);
    localparam int NCW   = (KW > NC_BITS) ? KW : NC_BITS;
    localparam int SW    = DIST_BITS + KW;
    localparam int DCNTW = $clog2(SW + 1);
    localparam int SCNTW = $clog2(ROOT_BITS + 1);
    localparam int VW    = 2 * ROOT_BITS;

    // point store
    logic [COORD_BITS-1:0] mem_x [MAX_POINTS];
    logic [COORD_BITS-1:0] mem_y [MAX_POINTS];
    logic [COORD_BITS-1:0] r_rd_x, r_rd_y;
    logic [LW-1:0]         r_loaded;
    logic [XW-1:0]         idx_ext;
    logic [AW-1:0]         idx_addr, rd_addr;
    logic                  full;

    // scan
    logic [AW-1:0]         r_j, r_qidx;
    logic [COORD_BITS-1:0] r_qx, r_qy;
    logic                  r_v1, r_v2;
    logic [COORD_BITS-1:0] ax, ay;
    logic [2*COORD_BITS-1:0] sqx, sqy;
    logic [DIST_BITS-1:0]  r_d;

    // sorter
    logic [DIST_BITS-1:0]  r_best [MAX_NEIGHBORS];
    logic [DIST_BITS-1:0]  n_best [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] lt, in_k;
    logic [KW-1:0]         r_kept, k_eff;
    logic [NCW-1:0]        nc_ext;
    logic [DIST_BITS-1:0]  ev;
    logic                  kept_full, take;
    logic [SW-1:0]         r_sum;

    // divider
    logic [SW-1:0]         r_dq;
    logic [KW-1:0]         r_drem;
    logic [DCNTW-1:0]      r_dcnt;
    logic [KW:0]           dtrial;
    logic                  dge;

    // square root
    logic [VW-1:0]         r_sv;
    logic [ROOT_BITS+1:0]  r_sr;
    logic [ROOT_BITS-1:0]  r_root;
    logic [SCNTW-1:0]      r_scnt;
    logic [ROOT_BITS+3:0]  srem, strial;
    logic                  sge;

    logic [ROOT_BITS-1:0]  r_mean;
    logic [STS_BITS-1:0]   r_status;

    assign idx_ext  = XW'(i_point_index);
    assign idx_addr = idx_ext[AW-1:0];
    assign full     = (r_loaded == LW'(MAX_POINTS));
    assign rd_addr  = i_cmd.fetch ? idx_addr : r_j;

    // store points and read one entry a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            mem_x[r_loaded[AW-1:0]] <= i_coord_x;
            mem_y[r_loaded[AW-1:0]] <= i_coord_y;
        end
        r_rd_x <= mem_x[rd_addr];
        r_rd_y <= mem_y[rd_addr];
    end

    // distance stage
    always_comb begin
        ax  = (r_qx >= r_rd_x) ? (r_qx - r_rd_x) : (r_rd_x - r_qx);
        ay  = (r_qy >= r_rd_y) ? (r_qy - r_rd_y) : (r_rd_y - r_qy);
        sqx = (2*COORD_BITS)'(ax) * (2*COORD_BITS)'(ax);
        sqy = (2*COORD_BITS)'(ay) * (2*COORD_BITS)'(ay);
    end

    // clamp neighbour count to the supported range
    always_comb begin
        nc_ext = NCW'(i_neighbor_count);
        if (nc_ext == '0) begin
            k_eff = KW'(1);
        end else if (nc_ext > NCW'(MAX_NEIGHBORS)) begin
            k_eff = KW'(MAX_NEIGHBORS);
        end else begin
            k_eff = nc_ext[KW-1:0];
        end
    end

    // insert into the sorted list; empty slots count as infinite
    always_comb begin
        ev = '0;
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            lt[i]   = (KW'(i) >= r_kept) || (r_d < r_best[i]);
            in_k[i] = (KW'(i) < k_eff);
            if (KW'(i) == k_eff - KW'(1)) begin
                ev = r_best[i];
            end
        end
        kept_full = (r_kept == k_eff);
        take      = r_v2 && (!kept_full || (r_d < ev));
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            n_best[i] = r_best[i];
        end
        if (r_v2 && in_k[0] && lt[0]) begin
            n_best[0] = r_d;
        end
        for (int i = 1; i < MAX_NEIGHBORS; i++) begin
            if (r_v2 && in_k[i] && lt[i]) begin
                n_best[i] = lt[i-1] ? r_best[i-1] : r_d;
            end
        end
    end

    // divider step
    always_comb begin
        dtrial = {r_drem, r_dq[SW-1]};
        dge    = (dtrial >= {1'b0, r_kept});
    end

    // square root step
    always_comb begin
        srem   = {r_sr, r_sv[VW-1:VW-2]};
        strial = (ROOT_BITS+4)'({r_root, 2'b01});
        sge    = (srem >= strial);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_kept   <= '0;
            r_dcnt   <= '0;
            r_scnt   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_loaded <= '0;
            end else if (i_cmd.load && !full) begin
                r_loaded <= r_loaded + LW'(1);
            end
            r_v1 <= i_cmd.scan_run && (r_j != r_qidx);
            r_v2 <= r_v1;
            if (i_cmd.scan_init) begin
                r_kept <= '0;
            end else if (r_v2 && !kept_full) begin
                r_kept <= r_kept + KW'(1);
            end
            if (i_cmd.div_start) begin
                r_dcnt <= (r_kept == '0) ? '0 : DCNTW'(SW);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - DCNTW'(1);
            end
            if (i_cmd.sq_start) begin
                r_scnt <= SCNTW'(ROOT_BITS);
            end else if (r_scnt != '0) begin
                r_scnt <= r_scnt - SCNTW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_qidx <= idx_addr;
        end
        if (i_cmd.scan_init) begin
            r_qx  <= r_rd_x;
            r_qy  <= r_rd_y;
            r_j   <= '0;
            r_sum <= '0;
        end else begin
            if (i_cmd.scan_run) begin
                r_j <= r_j + AW'(1);
            end
            if (take) begin
                r_sum <= r_sum + SW'(r_d) - (kept_full ? SW'(ev) : '0);
            end
        end
        r_d <= DIST_BITS'(sqx) + DIST_BITS'(sqy);
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            r_best[i] <= n_best[i];
        end
        // divide sum by kept count, one quotient bit a cycle; with nothing kept, load the fallback square
        if (i_cmd.div_start) begin
            r_dq   <= (r_kept == '0) ? SW'(i_fallback_sq) : r_sum;
            r_drem <= '0;
        end else if (r_dcnt != '0) begin
            r_drem <= dge ? KW'(dtrial - {1'b0, r_kept}) : dtrial[KW-1:0];
            r_dq   <= {r_dq[SW-2:0], dge};
        end
        // square root, one root bit a cycle
        if (i_cmd.sq_start) begin
            r_sv   <= VW'(r_dq[DIST_BITS-1:0]);
            r_sr   <= '0;
            r_root <= '0;
        end else if (r_scnt != '0) begin
            r_sv   <= {r_sv[VW-3:0], 2'b00};
            r_sr   <= sge ? (ROOT_BITS+2)'(srem - strial) : srem[ROOT_BITS+1:0];
            r_root <= {r_root[ROOT_BITS-2:0], sge};
        end
        // result register
        if (i_cmd.res_load) begin
            r_mean   <= i_cmd.res_root ? r_root : '0;
            r_status <= i_cmd.res_status;
        end
    end

    assign o_stat.full       = full;
    assign o_stat.idx_ok     = (CW'(i_point_index) < CW'(r_loaded));
    assign o_stat.scan_last  = (LW'(r_j) == r_loaded - LW'(1));
    assign o_stat.pipe_empty = !r_v1 && !r_v2;
    assign o_stat.div_done   = (r_dcnt == '0);
    assign o_stat.sq_done    = (r_scnt == '0);

    assign o_mean_distance = r_mean;
    assign o_status        = r_status;

endmodule

// ===== rtl/knnmd_ctrl.sv =====
// Controller: command decode, query sequencing and output handshake.
module knnmd_ctrl
    import knnmd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic [CMD_BITS-1:0] i_cmd_code,
    input  logic                i_m_tready,
    input  t_dp_stat            i_stat,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    output t_dp_cmd             o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_QLATCH, S_SCAN, S_DRAIN, S_DIV, S_DIVW, S_SQ, S_SQW, S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic                r_m_valid;
    logic                r_use_root, n_use_root;
    logic [STS_BITS-1:0] r_status, n_status;
    logic                accept, out_free;

    assign accept   = i_s_tvalid && (r_state == S_IDLE);
    assign out_free = !r_m_valid || i_m_tready;

    // decode state into datapath commands
    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_use_root = r_use_root;
        n_status   = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state    = S_OUT;
                    n_use_root = 1'b0;
                    n_status   = STS_OK;
                    unique case (i_cmd_code)
                        CMD_LOAD: begin
                            o_cmd.load = 1'b1;
                            if (i_stat.full) begin
                                n_status = STS_FULL;
                            end
                        end
                        CMD_QUERY: begin
                            if (i_stat.idx_ok) begin
                                o_cmd.fetch = 1'b1;
                                n_use_root  = 1'b1;
                                n_state     = S_QLATCH;
                            end else begin
                                n_status = STS_NOIDX;
                            end
                        end
                        CMD_CLEAR: o_cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_QLATCH: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq_start = 1'b1;
                n_state        = S_SQW;
            end
            S_SQW: begin
                if (i_stat.sq_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_root   = r_use_root;
                    o_cmd.res_status = r_status;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state, result flags and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_valid  <= 1'b0;
            r_use_root <= 1'b0;
            r_status   <= STS_OK;
        end else begin
            r_state    <= n_state;
            r_use_root <= n_use_root;
            r_status   <= n_status;
            if (o_cmd.res_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule

// ===== tb/knn_mean_distance_tb.sv =====
// Self-checking testbench for the k-nearest-neighbour mean distance block.
module knn_mean_distance_tb
    import knnmd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS    = 256;
    localparam int NNB     = 8;
    localparam int N_RAND  = 1680;
    localparam int WDOG    = 20000;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [STS_BITS-1:0] status;
        logic [12:0]         distance;
    } t_answer;

    typedef struct {
        logic [CMD_BITS-1:0] cmd;
        logic [11:0]         cx;
        logic [11:0]         cy;
        logic [IDX_BITS-1:0] idx;
        bit                  typed;
        t_answer             ans;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [FB_BITS-1:0]      i_cfg_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [39:0]             s_tdata = '0;  // cmd, coord_x, coord_y, point_index, zero pad
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [15:0]             m_tdata;       // mean_distance, status, zero pad

    knn_mean_distance u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [11:0] px [NPTS];
    logic [11:0] py [NPTS];
    int unsigned n_loaded;
    logic [NC_BITS-1:0] k_cfg;
    logic [FB_BITS-1:0] fb_cfg;

    t_answer     answers_due [$];
    int unsigned n_mismatch;
    int unsigned idle_cycles = 0;
    bit          calm;
    bit          timed_out;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic t_answer predict_answer(input logic [CMD_BITS-1:0] cmd,
            input logic [11:0] cx, input logic [11:0] cy, input logic [IDX_BITS-1:0] idx);
        t_answer a;
        logic [63:0] best [NNB];
        logic [63:0] d, sum, mean;
        longint dx, dy;
        int unsigned kept, k, m;
        a = '0;
        if (cmd == CMD_LOAD) begin
            if (n_loaded >= NPTS) a.status = STS_FULL;
            else begin
                px[n_loaded] = cx;
                py[n_loaded] = cy;
                n_loaded++;
            end
        end else if (cmd == CMD_QUERY) begin
            if (idx >= n_loaded) a.status = STS_NOIDX;
            else begin
                k = (k_cfg < 1) ? 1 : (k_cfg > NNB) ? NNB : k_cfg;
                kept = 0;
                for (int j = 0; j < n_loaded; j++) begin
                    if (j == idx) continue;
                    dx = longint'(px[idx]) - longint'(px[j]);
                    dy = longint'(py[idx]) - longint'(py[j]);
                    d = dx * dx + dy * dy;
                    if (kept < k) begin
                        m = kept;
                        kept++;
                    end
                    else if (d < best[k-1]) m = k - 1;
                    else continue;
                    while (m > 0 && best[m-1] > d) begin
                        best[m] = best[m-1];
                        m--;
                    end
                    best[m] = d;
                end
                if (kept == 0) mean = fb_cfg;
                else begin
                    sum = 0;
                    for (int i = 0; i < kept; i++) sum += best[i];
                    mean = sum / kept;
                end
                a.distance = 13'(int_sqrt(mean));
            end
        end else if (cmd == CMD_CLEAR) begin
            n_loaded = 0;
        end
        return a;
    endfunction

    // drain results with random stalls and check against the oldest answer
    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = t_answer'(m_tdata[14:0]);
                if (answers_due.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    want = answers_due.pop_front();
                    if (got.distance !== want.distance || got.status !== want.status
                            || m_tdata[15] !== 1'b0) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch: dist exp %0d got %0d, status exp %0d got %0d",
                                     want.distance, got.distance, want.status, got.status);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 27);
        end
    end

    // count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles > WDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] r, input logic [FB_BITS-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (r == REG_NEIGHBOR_COUNT) k_cfg = v[NC_BITS-1:0];
        else fb_cfg = v;
    endtask

    // hold until every answer has arrived, then let the block settle
    task automatic drain_all();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // present one command, hold until the transfer, queue its answer
    task automatic send_cmd(input logic [CMD_BITS-1:0] cmd, input logic [11:0] cx,
            input logic [11:0] cy, input logic [IDX_BITS-1:0] idx, input bit typed,
            input t_answer ans);
        t_answer p;
        while (!calm && $urandom_range(99) < 27) @(posedge i_clk);
        s_tdata  <= {6'd0, idx, cy, cx, cmd};
        s_tvalid <= 1'b1;
        p = predict_answer(cmd, cx, cy, idx);
        if (typed && p !== ans) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("table row disagrees with predictor");
        end
        answers_due = {answers_due, p};
        do @(posedge i_clk); while (!s_tready);
        s_tvalid <= 1'b0;
        // the block leaves idle on a transfer, so ready drops in the cycle after it
        @(posedge i_clk);
    endtask

    t_row table_rows [$];

    task automatic add_row(input logic [CMD_BITS-1:0] c, input int x, input int y, input int i,
            input bit t, input int d, input logic [STS_BITS-1:0] s);
        t_row r;
        r.cmd = c; r.cx = 12'(x); r.cy = 12'(y); r.idx = IDX_BITS'(i); r.typed = t;
        r.ans.distance = 13'(d); r.ans.status = s;
        table_rows = {table_rows, r};
    endtask

    task automatic random_cmd();
        int unsigned sel;
        logic [IDX_BITS-1:0] qi, ri;
        logic [11:0] rx, ry;
        sel = $urandom_range(99);
        rx = 12'($urandom);
        ry = 12'($urandom);
        ri = IDX_BITS'($urandom);
        qi = (n_loaded > 0 && sel < 90) ? IDX_BITS'($urandom_range(n_loaded - 1)) : ri;
        if (sel < 55 || (n_loaded < 2 && sel < 80))
            send_cmd(CMD_LOAD, rx, ry, ri, 0, '0);
        else if (sel < 93)
            send_cmd(CMD_QUERY, rx, ry, qi, 0, '0);
        else if (sel < 97)
            send_cmd(CMD_CLEAR, rx, ry, ri, 0, '0);
        else
            send_cmd(CMD_UNUSED, rx, ry, ri, 0, '0);
    endtask

    initial begin
        n_loaded = 0; k_cfg = NC_RESET; fb_cfg = FB_RESET;
        n_mismatch = 0; calm = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: empty query, fallback, extremes, unused command
        add_row(CMD_QUERY, 0, 0, 0, 1, 0, STS_NOIDX);
        add_row(CMD_LOAD, 0, 0, 0, 1, 0, STS_OK);
        add_row(CMD_QUERY, 0, 0, 0, 1, 3394, STS_OK);
        add_row(CMD_QUERY, 0, 0, 255, 1, 0, STS_NOIDX);
        add_row(CMD_LOAD, 4095, 4095, 0, 1, 0, STS_OK);
        add_row(CMD_QUERY, 0, 0, 1, 1, 5791, STS_OK);
        add_row(CMD_LOAD, 4095, 0, 0, 1, 0, STS_OK);
        add_row(CMD_LOAD, 0, 4095, 0, 1, 0, STS_OK);
        add_row(CMD_QUERY, 0, 0, 0, 0, 0, STS_OK);
        add_row(CMD_QUERY, 0, 0, 3, 0, 0, STS_OK);
        add_row(CMD_UNUSED, 4095, 4095, 255, 1, 0, STS_OK);
        add_row(CMD_CLEAR, 0, 0, 0, 1, 0, STS_OK);
        add_row(CMD_QUERY, 0, 0, 0, 1, 0, STS_NOIDX);
        foreach (table_rows[r])
            send_cmd(table_rows[r].cmd, table_rows[r].cx, table_rows[r].cy, table_rows[r].idx,
                     table_rows[r].typed, table_rows[r].ans);

        // fill the table to overflow, with the largest neighbour count
        drain_all();
        write_reg(REG_NEIGHBOR_COUNT, FB_BITS'(15));
        for (int i = 0; i < NPTS + 2; i++)
            send_cmd(CMD_LOAD, 12'($urandom), 12'($urandom), '0, 0, '0);
        send_cmd(CMD_QUERY, '0, '0, IDX_BITS'(255), 0, '0);
        send_cmd(CMD_CLEAR, '0, '0, '0, 0, '0);

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            drain_all();
            case (ph)
                0: begin write_reg(REG_NEIGHBOR_COUNT, '0); write_reg(REG_FALLBACK_SQ, '0); end
                1: begin write_reg(REG_NEIGHBOR_COUNT, FB_BITS'(1));
                         write_reg(REG_FALLBACK_SQ, FB_BITS'(33538050)); end
                2: begin write_reg(REG_NEIGHBOR_COUNT, FB_BITS'(8));
                         write_reg(REG_FALLBACK_SQ, 25'h1FFFFFF); end
                default: begin write_reg(REG_NEIGHBOR_COUNT, FB_BITS'($urandom));
                         write_reg(REG_FALLBACK_SQ, FB_BITS'($urandom)); end
            endcase
            calm = (ph == 3);
            for (int i = 0; i < N_RAND / 6; i++) begin
                if (n_loaded > 40 && $urandom_range(99) < 20)
                    send_cmd(CMD_CLEAR, '0, '0, '0, 0, '0);
                else random_cmd();
            end
        end
        calm = 0;

        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (n_mismatch == 0 && answers_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
